// ===== rtl/ssds_pkg.sv =====
// Shared types, constants and a lookup function for the seven-segment display serializer.
// Holds the request and response word structs, the microcode word and the segment map.
// Depends on nothing.
`default_nettype none

package ssds_pkg;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] number;
      logic [7:0]  char_0;
      logic [7:0]  char_1;
      logic [7:0]  char_2;
      logic [7:0]  char_3;
   } req_type;

   typedef struct packed {
      logic [1:0] cell_kind;
      logic       bit_value;
      logic       last;
   } rsp_type;

   localparam logic [1:0] ACTION_NUMBER = 2'd0;
   localparam logic [1:0] ACTION_CHARS  = 2'd1;
   localparam logic [1:0] ACTION_BRIGHT = 2'd2;
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BIT   = 2'd1;
   localparam logic [1:0] KIND_ACK   = 2'd2;
   localparam logic [1:0] KIND_STOP  = 2'd3;

   localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
   localparam logic [7:0] CMD_ADDR_ZERO = 8'hC0;
   localparam logic [7:0] CMD_DISP_BASE = 8'h87;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   localparam logic [3:0] BRIGHT_RESET = 4'd8;
   localparam logic [3:0] BRIGHT_MAX   = 4'd8;

   localparam logic [15:0] NUMBER_LIMIT = 16'd10000;
   localparam int          DIGIT_WIDTH  = 14;

   localparam int          STEP_WIDTH  = 5;
   localparam logic [4:0]  ENTRY_DIGIT  = 5'd0;
   localparam logic [4:0]  ENTRY_DISP   = 5'd4;
   localparam logic [4:0]  ENTRY_BRIGHT = 5'd20;

   typedef enum logic {
      OP_CELL,
      OP_DIGIT
   } op_type;

   typedef enum logic [2:0] {
      SRC_DATA_CMD,
      SRC_ADDR_CMD,
      SRC_SEG0,
      SRC_SEG1,
      SRC_SEG2,
      SRC_SEG3,
      SRC_BRIGHT
   } src_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] kind;
      src_type    src;
      logic       rpt;
      logic       last;
   } ucode_type;

   typedef struct packed {
      logic                  busy;
      ucode_type             uop;
      logic [2:0]            bit_idx;
      logic [1:0]            digit_pos;
   } seq_status_type;

   function automatic logic [7:0] segment_code(input logic [7:0] ch);
      logic [7:0] code;
      unique case (ch)
         8'h30:   code = 8'h3f;
         8'h31:   code = 8'h06;
         8'h32:   code = 8'h5b;
         8'h33:   code = 8'h4f;
         8'h34:   code = 8'h66;
         8'h35:   code = 8'h6d;
         8'h36:   code = 8'h7d;
         8'h37:   code = 8'h07;
         8'h38:   code = 8'h7f;
         8'h39:   code = 8'h6f;
         8'h61:   code = 8'h77;
         8'h62:   code = 8'h7c;
         8'h63:   code = 8'h39;
         8'h64:   code = 8'h5e;
         8'h65:   code = 8'h79;
         8'h66:   code = 8'h71;
         8'h67:   code = 8'h3d;
         8'h68:   code = 8'h76;
         8'h20:   code = 8'h00;
         8'h6f:   code = 8'h5c;
         8'h6e:   code = 8'h54;
         8'h72:   code = 8'h50;
         8'h73:   code = 8'h6d;
         8'h2d:   code = 8'h40;
         8'h2b:   code = 8'h46;
         8'h5f:   code = 8'h08;
         default: code = 8'h2b;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ssds_sequencer.sv =====
// Microcode sequencer: program ROM, step counter and bit counter.
// Drives the serializer datapath through one control word per step; uses ssds_pkg.
`default_nettype none

module ssds_sequencer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [4:0]               entry,
   input  wire logic                     advance,
   output ssds_pkg::seq_status_type      status
);
   import ssds_pkg::*;

   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [2:0]            bit_ff, bit_in;
   logic                  busy_ff, busy_in;
   ucode_type             uop;

   // Program: number entry converts four digits, then falls into the display run.
   always_comb begin
      uop = '{op: OP_CELL, kind: KIND_STOP, src: SRC_DATA_CMD, rpt: 1'b0, last: 1'b1};
      unique case (step_ff)
         5'd0, 5'd1, 5'd2, 5'd3:
            uop = '{op: OP_DIGIT, kind: KIND_START, src: SRC_DATA_CMD, rpt: 1'b0,
                    last: 1'b0};
         5'd4:  uop = '{OP_CELL, KIND_START, SRC_DATA_CMD, 1'b0, 1'b0};
         5'd5:  uop = '{OP_CELL, KIND_BIT,   SRC_DATA_CMD, 1'b1, 1'b0};
         5'd6:  uop = '{OP_CELL, KIND_ACK,   SRC_DATA_CMD, 1'b0, 1'b0};
         5'd7:  uop = '{OP_CELL, KIND_STOP,  SRC_DATA_CMD, 1'b0, 1'b0};
         5'd8:  uop = '{OP_CELL, KIND_START, SRC_ADDR_CMD, 1'b0, 1'b0};
         5'd9:  uop = '{OP_CELL, KIND_BIT,   SRC_ADDR_CMD, 1'b1, 1'b0};
         5'd10: uop = '{OP_CELL, KIND_ACK,   SRC_ADDR_CMD, 1'b0, 1'b0};
         5'd11: uop = '{OP_CELL, KIND_BIT,   SRC_SEG0,     1'b1, 1'b0};
         5'd12: uop = '{OP_CELL, KIND_ACK,   SRC_SEG0,     1'b0, 1'b0};
         5'd13: uop = '{OP_CELL, KIND_BIT,   SRC_SEG1,     1'b1, 1'b0};
         5'd14: uop = '{OP_CELL, KIND_ACK,   SRC_SEG1,     1'b0, 1'b0};
         5'd15: uop = '{OP_CELL, KIND_BIT,   SRC_SEG2,     1'b1, 1'b0};
         5'd16: uop = '{OP_CELL, KIND_ACK,   SRC_SEG2,     1'b0, 1'b0};
         5'd17: uop = '{OP_CELL, KIND_BIT,   SRC_SEG3,     1'b1, 1'b0};
         5'd18: uop = '{OP_CELL, KIND_ACK,   SRC_SEG3,     1'b0, 1'b0};
         5'd19: uop = '{OP_CELL, KIND_STOP,  SRC_SEG3,     1'b0, 1'b1};
         5'd20: uop = '{OP_CELL, KIND_START, SRC_BRIGHT,   1'b0, 1'b0};
         5'd21: uop = '{OP_CELL, KIND_BIT,   SRC_BRIGHT,   1'b1, 1'b0};
         5'd22: uop = '{OP_CELL, KIND_ACK,   SRC_BRIGHT,   1'b0, 1'b0};
         5'd23: uop = '{OP_CELL, KIND_STOP,  SRC_BRIGHT,   1'b0, 1'b1};
         default: uop = '{OP_CELL, KIND_STOP, SRC_DATA_CMD, 1'b0, 1'b1};
      endcase
   end

   // A repeating step holds the step counter until all eight bits have gone out.
   always_comb begin
      step_in = step_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         step_in = entry;
         bit_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff && advance) begin
         if (uop.rpt && (bit_ff != 3'd7)) begin
            bit_in = bit_ff + 3'd1;
         end else begin
            bit_in = '0;
            if (uop.last) begin
               busy_in = 1'b0;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         bit_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         bit_ff  <= bit_in;
         busy_ff <= busy_in;
      end
   end

   assign status.busy      = busy_ff;
   assign status.uop       = uop;
   assign status.bit_idx   = bit_ff;
   assign status.digit_pos = ~step_ff[1:0];

endmodule

`default_nettype wire

// ===== rtl/seven_segment_display_serializer.sv =====
// Top level of the seven-segment display serializer: request decode, digit datapath,
// byte selection and the registered response word. Uses ssds_pkg and ssds_sequencer.
`default_nettype none

// Each request word becomes a run of bus cells (start, data bit, ack slot, stop), one
// response word per cell. A display request yields 58 cells and a brightness request 11;
// action 3 is taken and produces nothing. The block works on one request at a time; a
// number request from 1 to 9999 first converts its four digits (one decimal digit per
// cycle through a reciprocal multiply). The microcode sequencer issues one cell per
// cycle while the response side is not stalled. The next request is taken as soon as
// the last cell sits in the output register.
module seven_segment_display_serializer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire ssds_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      ssds_pkg::rsp_type rsp_data,
   input  wire logic              csr_we,
   input  wire logic [3:0]        csr_wdata
);
   import ssds_pkg::*;

   seq_status_type           seq;
   logic                     accept;
   logic                     start;
   logic [STEP_WIDTH-1:0]    entry;
   logic                     out_free;
   logic                     advance;

   logic [3:0]               bright_ff;
   logic [DIGIT_WIDTH-1:0]   value_ff, value_in;
   logic [7:0]               text_ff [4];
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;

   logic [29:0]              product;
   logic [DIGIT_WIDTH-1:0]   quot;
   logic [DIGIT_WIDTH-1:0]   rem;
   logic [7:0]               digit_char;
   logic [3:0]               level;
   logic [7:0]               cur_byte;

   ssds_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .entry   (entry),
      .advance (advance),
      .status  (seq)
   );

   assign req_stall = seq.busy;
   assign accept    = req_valid & ~seq.busy;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = seq.busy & ((seq.uop.op == OP_DIGIT) | out_free);

   always_comb begin
      start = 1'b0;
      entry = ENTRY_DISP;
      if (accept) begin
         unique case (req_data.action)
            ACTION_NUMBER: begin
               start = 1'b1;
               if ((req_data.number != '0) && (req_data.number < NUMBER_LIMIT)) begin
                  entry = ENTRY_DIGIT;
               end
            end
            ACTION_CHARS:  start = 1'b1;
            ACTION_BRIGHT: begin
               start = 1'b1;
               entry = ENTRY_BRIGHT;
            end
            default:       start = 1'b0;
         endcase
      end
   end

   // Divide by ten through a reciprocal: exact for every value below 10000.
   assign product    = 30'(value_ff) * 30'd52429;
   assign quot       = DIGIT_WIDTH'(product[29:19]);
   assign rem        = value_ff - ((quot << 3) + (quot << 1));
   assign digit_char = (value_ff != '0) ? (CHAR_ZERO + 8'(rem[3:0])) : CHAR_SPACE;
   assign value_in   = quot;

   assign level = (bright_ff > BRIGHT_MAX) ? BRIGHT_MAX : bright_ff;

   always_comb begin
      unique case (seq.uop.src)
         SRC_DATA_CMD: cur_byte = CMD_DATA_AUTO;
         SRC_ADDR_CMD: cur_byte = CMD_ADDR_ZERO;
         SRC_SEG0:     cur_byte = segment_code(text_ff[0]);
         SRC_SEG1:     cur_byte = segment_code(text_ff[1]);
         SRC_SEG2:     cur_byte = segment_code(text_ff[2]);
         SRC_SEG3:     cur_byte = segment_code(text_ff[3]);
         SRC_BRIGHT:   cur_byte = CMD_DISP_BASE + {4'd0, level};
         default:      cur_byte = CMD_DATA_AUTO;
      endcase
   end

   always_comb begin
      rsp_in.cell_kind = seq.uop.kind;
      rsp_in.bit_value = (seq.uop.kind == KIND_BIT) ? cur_byte[seq.bit_idx] : 1'b0;
      rsp_in.last      = seq.uop.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff    <= BRIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            bright_ff <= csr_wdata;
         end
         if (advance && (seq.uop.op == OP_CELL)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && (seq.uop.op == OP_CELL)) begin
         rsp_ff <= rsp_in;
      end
      if (accept && (req_data.action == ACTION_NUMBER)) begin
         value_ff <= req_data.number[DIGIT_WIDTH-1:0];
         if (req_data.number == '0) begin
            text_ff[0] <= CHAR_SPACE;
            text_ff[1] <= CHAR_SPACE;
            text_ff[2] <= CHAR_SPACE;
            text_ff[3] <= CHAR_ZERO;
         end else if (req_data.number >= NUMBER_LIMIT) begin
            text_ff[0] <= CHAR_ZERO;
            text_ff[1] <= CHAR_ZERO;
            text_ff[2] <= CHAR_ZERO;
            text_ff[3] <= CHAR_ZERO;
         end
      end else if (accept && (req_data.action == ACTION_CHARS)) begin
         text_ff[0] <= req_data.char_0;
         text_ff[1] <= req_data.char_1;
         text_ff[2] <= req_data.char_2;
         text_ff[3] <= req_data.char_3;
      end else if (advance && (seq.uop.op == OP_DIGIT)) begin
         // Digits come out least significant first, filling from the right.
         value_ff                <= value_in;
         text_ff[seq.digit_pos]  <= digit_char;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/ssds_checker.sv =====
// Port-level checker for the seven-segment display serializer, with its bind.
// Uses ssds_pkg for the cell kinds and request actions.
`default_nettype none

module ssds_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire ssds_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire ssds_pkg::rsp_type rsp_data
);
   import ssds_pkg::*;

   // A stalled response word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // A request that produces cells keeps the input stalled while it runs.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.action != ACTION_UNUSED) |=> req_stall)
      else $error("request side not stalled after a run started");

   // Only data bit cells carry a line level.
   a_level_only_on_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.cell_kind != KIND_BIT) |-> !rsp_data.bit_value)
      else $error("nonzero level on a cell that is not a data bit");

   // Every run closes with a stop condition.
   a_last_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> (rsp_data.cell_kind == KIND_STOP))
      else $error("last cell of a run is not a stop");

endmodule

bind seven_segment_display_serializer ssds_checker u_ssds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== bench/seven_segment_display_serializer_test.sv =====
// Self-checking testbench for seven_segment_display_serializer: predicts every bus cell
// of each request word and compares it with the response words. Depends on ssds_pkg.
module seven_segment_display_serializer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ssds_pkg::*;

   localparam int SETTLE_CYCLES = 80;
   localparam int QUIET_LIMIT   = 4000;
   localparam int REPORT_LIMIT  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_wdata = '0;

   rsp_type     expected_cells[$];
   logic [3:0]  brightness_copy = BRIGHT_RESET;
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   seven_segment_display_serializer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [7:0] glyph_code(input logic [7:0] ch);
      case (ch)
         "0": return 8'h3f;
         "1": return 8'h06;
         "2": return 8'h5b;
         "3": return 8'h4f;
         "4": return 8'h66;
         "5": return 8'h6d;
         "6": return 8'h7d;
         "7": return 8'h07;
         "8": return 8'h7f;
         "9": return 8'h6f;
         "a": return 8'h77;
         "b": return 8'h7c;
         "c": return 8'h39;
         "d": return 8'h5e;
         "e": return 8'h79;
         "f": return 8'h71;
         "g": return 8'h3d;
         "h": return 8'h76;
         "o": return 8'h5c;
         "n": return 8'h54;
         "r": return 8'h50;
         "s": return 8'h6d;
         " ": return 8'h00;
         "-": return 8'h40;
         "+": return 8'h46;
         "_": return 8'h08;
         default: return 8'h2b;
      endcase
   endfunction

   // Leftmost character in the top byte.
   function automatic logic [31:0] number_text(input logic [15:0] n);
      logic [31:0] t;
      int v;
      if (n == 16'd0) begin
         t = {CHAR_SPACE, CHAR_SPACE, CHAR_SPACE, CHAR_ZERO};
      end else if (n >= NUMBER_LIMIT) begin
         t = {4{CHAR_ZERO}};
      end else begin
         v = n;
         for (int i = 0; i < 4; i++) begin
            t[8*i +: 8] = (v != 0) ? CHAR_ZERO + 8'(v % 10) : CHAR_SPACE;
            v = v / 10;
         end
      end
      return t;
   endfunction

   function automatic void push_cell(input logic [1:0] kind, input logic level,
                                     input logic fin);
      rsp_type c;
      c.cell_kind = kind;
      c.bit_value = level;
      c.last      = fin;
      expected_cells.push_back(c);
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      for (int k = 0; k < 8; k++) push_cell(KIND_BIT, b[k], 1'b0);
      push_cell(KIND_ACK, 1'b0, 1'b0);
   endfunction

   function automatic void predict_cells(input req_type w);
      logic [31:0] text;
      logic [3:0]  level;
      case (w.action)
         ACTION_BRIGHT: begin
            level = (brightness_copy > BRIGHT_MAX) ? BRIGHT_MAX : brightness_copy;
            push_cell(KIND_START, 1'b0, 1'b0);
            push_byte(CMD_DISP_BASE + 8'(level));
            push_cell(KIND_STOP, 1'b0, 1'b1);
         end
         ACTION_NUMBER, ACTION_CHARS: begin
            if (w.action == ACTION_NUMBER) text = number_text(w.number);
            else text = {w.char_0, w.char_1, w.char_2, w.char_3};
            push_cell(KIND_START, 1'b0, 1'b0);
            push_byte(CMD_DATA_AUTO);
            push_cell(KIND_STOP, 1'b0, 1'b0);
            push_cell(KIND_START, 1'b0, 1'b0);
            push_byte(CMD_ADDR_ZERO);
            for (int i = 3; i >= 0; i--) push_byte(glyph_code(text[8*i +: 8]));
            push_cell(KIND_STOP, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void note_mismatch(input string what, input rsp_type exp_c);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s: expected kind=%0d bit=%0d last=%0d, got kind=%0d bit=%0d last=%0d",
                  $time, what, exp_c.cell_kind, exp_c.bit_value, exp_c.last,
                  rsp_data.cell_kind, rsp_data.bit_value, rsp_data.last);
   endfunction

   always @(posedge clock) begin
      rsp_type exp_c;
      if (!reset) begin
         if (req_valid && !req_stall) predict_cells(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               note_mismatch("unexpected word", '0);
            end else begin
               exp_c = expected_cells.pop_front();
               if (rsp_data.cell_kind !== exp_c.cell_kind ||
                   rsp_data.bit_value !== exp_c.bit_value ||
                   rsp_data.last !== exp_c.last)
                  note_mismatch("wrong word", exp_c);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("seven_segment_display_serializer verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- driving

   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_cells.size() != 0);
      @(posedge clock);
   endtask

   // A request with no cells may still be in flight when the queue runs empty.
   task automatic write_brightness(input logic [3:0] value);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      brightness_copy = value;
   endtask

   function automatic req_type random_word();
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      return noise[$bits(req_type)-1:0];
   endfunction

   function automatic req_type number_word(input logic [15:0] n);
      req_type w;
      w = random_word();
      w.action = ACTION_NUMBER;
      w.number = n;
      return w;
   endfunction

   function automatic req_type chars_word(input logic [31:0] t);
      req_type w;
      w = random_word();
      w.action = ACTION_CHARS;
      {w.char_0, w.char_1, w.char_2, w.char_3} = t;
      return w;
   endfunction

   function automatic req_type bright_word();
      req_type w;
      w = random_word();
      w.action = ACTION_BRIGHT;
      return w;
   endfunction

   function automatic logic [7:0] pick_char();
      string mapped;
      mapped = "0123456789abcdefghonrs -+_";
      if ($urandom_range(99) < 80) return mapped[$urandom_range(mapped.len() - 1)];
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [15:0] pick_number();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'($urandom_range(9));
         2: return 16'($urandom_range(99));
         3: return 16'($urandom_range(999));
         4, 5: return 16'($urandom_range(9999));
         6: return 16'($urandom_range(10010, 9990));
         9: return 16'hFFFF - 16'($urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_brightness();
      send_word(bright_word());
   endtask

   task automatic test_number_conversion();
      send_word(number_word(16'd0));
      send_word(number_word(16'd1));
      send_word(number_word(16'd305));
      send_word(number_word(16'd9999));
      send_word(number_word(16'd10000));
      send_word(number_word(16'hFFFF));
   endtask

   task automatic test_character_map();
      send_word(chars_word("0123"));
      send_word(chars_word("4567"));
      send_word(chars_word("89ab"));
      send_word(chars_word("cdef"));
      send_word(chars_word("gh o"));
      send_word(chars_word("nrs-"));
      send_word(chars_word("+_ A"));
      send_word(chars_word({8'h00, 8'h80, 8'hFF, 8'h2F}));
   endtask

   // Values above eight saturate to the top level.
   task automatic test_brightness_levels();
      logic [3:0] levels [6] = '{4'd0, 4'd1, 4'd7, 4'd9, 4'd15, 4'd8};
      foreach (levels[i]) begin
         write_brightness(levels[i]);
         send_word(bright_word());
      end
   endtask

   task automatic test_unused_action();
      req_type w;
      w = random_word();
      w.action = ACTION_UNUSED;
      send_word(w);
      send_word(bright_word());
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count, input logic [3:0] level);
      req_type w;
      int r;
      int sent;
      write_brightness(level);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         w = random_word();
         r = $urandom_range(99);
         if (r < 40) begin
            w.action = ACTION_NUMBER;
            w.number = pick_number();
         end else if (r < 80) begin
            w.action = ACTION_CHARS;
            w.char_0 = pick_char();
            w.char_1 = pick_char();
            w.char_2 = pick_char();
            w.char_3 = pick_char();
         end else if (r < 94) begin
            w.action = ACTION_BRIGHT;
         end else begin
            w.action = ACTION_UNUSED;
         end
         send_word(w);
         if (w.action != ACTION_UNUSED) sent++;
         // Let the block run dry once per phase before feeding it again.
         if (sent == count / 2 && w.action != ACTION_UNUSED) wait_for_results();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_brightness();
      test_number_conversion();
      test_character_map();
      test_brightness_levels();
      test_unused_action();
      test_random_traffic(0, 0, 80, 4'd8);
      test_random_traffic(76, 0, 80, 4'd0);
      test_random_traffic(0, 76, 80, 4'd15);
      test_random_traffic(6, 6, 50, 4'($urandom_range(15)));
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_cells.size() == 0) begin
         $display("seven_segment_display_serializer verification clean");
      end else begin
         $display("seven_segment_display_serializer verification failed");
      end
      $finish;
   end

endmodule
